// ===== hdl/osvm_pkg.sv =====
// Package for the online linear SVM trainer.
// Holds sizes, register indexes, the divider request type and shared helpers.
// No dependencies.
`default_nettype none

package osvm_pkg;

    localparam int DIM    = 128;
    localparam int AW     = (DIM > 1) ? $clog2(DIM) : 1;
    localparam int IDX_W  = $clog2(DIM + 1);
    localparam int ACC_W  = 48 + $clog2(DIM);
    localparam int NUM_W  = 52;
    localparam int DEN_W  = 64;
    localparam int QCNT_W = $clog2(NUM_W);

    localparam logic [1:0] CFG_REG_STRENGTH = 2'd0;
    localparam logic [1:0] CFG_START_STEP   = 2'd1;
    localparam logic [1:0] CFG_PROJECT_EN   = 2'd2;
    localparam logic [1:0] CFG_BIAS_EN      = 2'd3;

    typedef struct packed {
        logic             start;
        logic [NUM_W-1:0] num;
        logic [DEN_W-1:0] den;
    } t_div_req;

    function automatic logic [31:0] abs32(input logic [31:0] v);
        abs32 = v[31] ? (~v + 32'd1) : v;
    endfunction

    function automatic logic [15:0] abs16(input logic [15:0] v);
        abs16 = v[15] ? (~v + 16'd1) : v;
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [53:0] v);
        if (v > 54'sd2147483647)
            sat32 = 32'sh7FFFFFFF;
        else if (v < -54'sd2147483648)
            sat32 = 32'sh80000000;
        else
            sat32 = v[31:0];
    endfunction

endpackage

`default_nettype wire

// ===== hdl/osvm_ram.sv =====
// Simple dual-port synchronous RAM, one write and one registered read port.
// Generic; no package dependency.
`default_nettype none

module osvm_ram #(
    parameter int W = 32,
    parameter int D = 128
) (
    input  wire                              i_clk,
    input  wire                              i_we,
    input  wire  [(D > 1 ? $clog2(D) : 1)-1:0] i_waddr,
    input  wire  [W-1:0]                     i_wdata,
    input  wire  [(D > 1 ? $clog2(D) : 1)-1:0] i_raddr,
    output logic [W-1:0]                     o_rdata
);

    logic [W-1:0] r_mem [D];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

// ===== hdl/osvm_div.sv =====
// Restoring radix-2 unsigned divider, one quotient bit per cycle.
// Depends on osvm_pkg for operand widths and the request struct.
`default_nettype none

module osvm_div import osvm_pkg::*; (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  t_div_req         i_req,
    output logic             o_done,
    output logic [NUM_W-1:0] o_quo,
    output logic             o_rem_nz
);

    logic [NUM_W-1:0]  r_num;
    logic [DEN_W-1:0]  r_den;
    logic [DEN_W-1:0]  r_rem;
    logic [QCNT_W-1:0] r_cnt;
    logic              r_busy;
    logic              r_done;
    logic [DEN_W:0]    rem_sh;
    logic              q_bit;

    assign rem_sh = {r_rem, r_num[NUM_W-1]};
    assign q_bit  = rem_sh >= {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_num  <= i_req.num;
                r_den  <= i_req.den;
                r_rem  <= '0;
            end else if (r_busy) begin
                r_rem <= q_bit ? DEN_W'(rem_sh - {1'b0, r_den}) : DEN_W'(rem_sh);
                r_num <= {r_num[NUM_W-2:0], q_bit};
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == QCNT_W'(NUM_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done   = r_done;
    assign o_quo    = r_num;
    assign o_rem_nz = |r_rem;

endmodule

`default_nettype wire

// ===== hdl/osvm_isqrt.sv =====
// Integer square root of a 64-bit value, two radicand bits per cycle.
// No package dependency.
`default_nettype none

module osvm_isqrt (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_start,
    input  wire  [63:0] i_value,
    output logic        o_done,
    output logic [31:0] o_root
);

    logic [63:0] r_v;
    logic [63:0] r_r;
    logic [63:0] r_bit;
    logic [4:0]  r_cnt;
    logic        r_busy;
    logic        r_done;
    logic [63:0] trial;

    assign trial = r_r + r_bit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_v    <= i_value;
                r_r    <= '0;
                r_bit  <= 64'h4000_0000_0000_0000;
            end else if (r_busy) begin
                if (r_v >= trial) begin
                    r_v <= r_v - trial;
                    r_r <= (r_r >> 1) + r_bit;
                end else begin
                    r_r <= r_r >> 1;
                end
                r_bit <= r_bit >> 2;
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == 5'd31) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_root = r_r[31:0];

endmodule

`default_nettype wire

// ===== hdl/online_linear_svm_sgd.sv =====
// Top level of the online linear SVM trainer (Pegasos style SGD).
// Depends on osvm_pkg, osvm_ram, osvm_div and osvm_isqrt.
//
// Feature elements stream in one per item: for each, the weight is read from
// the weight RAM, multiplied, and accumulated. The last element yields one
// result item. Evaluate passes through S_SCORE and S_DEN, then waits in S_OUT
// for the result side. Update walks the weight RAM once, one weight at a time
// through a shared 52-step divider, with a second division for each weight
// that learns, and does the same for the bias when enabled; projection sums
// the norm, takes the square root, divides for the scale and rescales the
// weights.
`default_nettype none

module online_linear_svm_sgd import osvm_pkg::*; (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_s_tvalid,
    output logic        o_s_tready,
    input  wire  [15:0] i_s_tdata,   // [15:0] element
    input  wire         i_s_tlast,
    input  wire  [2:0]  i_s_tuser,   // [1:0] label, [2] action
    output logic        o_m_tvalid,
    input  wire         i_m_tready,
    output logic [47:0] o_m_tdata,   // [47:0] score
    output logic [1:0]  o_m_tuser,   // [0] violated, [1] projected
    input  wire         i_cfg_we,
    input  wire  [1:0]  i_cfg_addr,
    input  wire  [31:0] i_cfg_wdata
);

    typedef enum logic [25:0] {
        S_IDLE = 26'd1 << 0,
        S_MAC1 = 26'd1 << 1,
        S_MAC2 = 26'd1 << 2,
        S_SCORE = 26'd1 << 3,
        S_DEN  = 26'd1 << 4,
        S_WRD  = 26'd1 << 5,
        S_WLAT = 26'd1 << 6,
        S_DIV1 = 26'd1 << 7,
        S_DIV2 = 26'd1 << 8,
        S_WWR  = 26'd1 << 9,
        S_BIAS = 26'd1 << 10,
        S_PCHK = 26'd1 << 11,
        S_NRD  = 26'd1 << 12,
        S_NLAT = 26'd1 << 13,
        S_NACC = 26'd1 << 14,
        S_PHI  = 26'd1 << 15,
        S_PHI2 = 26'd1 << 16,
        S_PLO  = 26'd1 << 17,
        S_SQRT = 26'd1 << 18,
        S_SDIV = 26'd1 << 19,
        S_SRD  = 26'd1 << 20,
        S_SLAT = 26'd1 << 21,
        S_SWR  = 26'd1 << 22,
        S_STEP = 26'd1 << 23,
        S_OUT  = 26'd1 << 24,
        S_SPARE = 26'd1 << 25
    } t_state;

    t_state r_state;

    logic [31:0]             r_lambda;
    logic                    r_proj_en;
    logic                    r_bias_en;
    logic [31:0]             r_step;
    logic signed [31:0]      r_bias;
    logic signed [ACC_W-1:0] r_acc;
    logic [IDX_W-1:0]        r_idx;
    logic [IDX_W-1:0]        r_count;
    logic [63:0]             r_norm;

    logic signed [15:0] r_x;
    logic               r_last;
    logic [1:0]         r_lab;
    logic               r_act;
    logic               r_inr;
    logic [AW-1:0]      r_i;
    logic [DEN_W-1:0]   r_den;
    logic signed [31:0] r_w;
    logic               r_isbias;
    logic signed [32:0] r_dec;
    logic signed [52:0] r_d;
    logic               r_dneg;
    logic               r_viol;
    logic               r_proj;
    logic [47:0]        r_score;
    logic [63:0]        r_phi;
    logic [31:0]        r_scale;
    logic               r_rdvld;
    logic [DIM-1:0]     r_wvld;
    logic signed [65:0] r_prod;

    logic               ovalid;
    logic [47:0]        odata;
    logic [1:0]         ouser;

    logic               s_acc;
    logic [31:0]        t_val;
    logic [31:0]        lr_val;
    logic               y_zero;
    logic               y_neg;
    logic [31:0]        w_q;
    logic [15:0]        x_q;
    logic signed [31:0] w_rd;
    logic [AW-1:0]      w_raddr;
    logic               w_we;
    logic signed [31:0] w_wdata;
    logic signed [32:0] mul_a;
    logic signed [32:0] mul_b;
    logic signed [63:0] score_sum;
    logic signed [47:0] score_c;
    logic               viol_c;
    logic [IDX_W-1:0]   i_ext;
    logic               learn;
    logic [31:0]        dec_mag;
    logic signed [31:0] upd_val;
    logic [64:0]        p_sum;
    logic [63:0]        p_val;
    logic [31:0]        sq_q;
    logic               div_done;
    logic [NUM_W-1:0]   div_q;
    logic               div_rnz;
    t_div_req           div_req;
    logic               sq_start;
    logic               sq_done;
    logic [31:0]        sq_root;
    logic               i_at_end;

    assign o_s_tready = (r_state == S_IDLE);
    assign s_acc      = i_s_tvalid && o_s_tready;
    assign t_val      = (r_step == 32'd0) ? 32'd1 : r_step;
    assign lr_val     = (r_lambda == 32'd0) ? 32'd1 : r_lambda;
    assign y_zero     = (r_lab == 2'd0);
    assign y_neg      = r_lab[1];
    assign i_ext      = IDX_W'(r_i);
    assign i_at_end   = (r_i == AW'(DIM - 1));

    // weight and sample stores
    assign w_raddr = (r_state == S_IDLE) ? r_idx[AW-1:0] : r_i;
    assign w_rd    = r_rdvld ? $signed(w_q) : 32'sd0;
    assign w_we    = ((r_state == S_WWR) && !r_isbias) || (r_state == S_SWR);
    assign sq_q    = 32'(r_prod[63:32]);
    assign w_wdata = (r_state == S_SWR) ? (r_w[31] ? -$signed(sq_q) : $signed(sq_q))
                                        : upd_val;

    osvm_ram #(.W(32), .D(DIM)) u_wram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (r_i),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_q)
    );

    osvm_ram #(.W(16), .D(DIM)) u_sram (
        .i_clk   (i_clk),
        .i_we    (s_acc && (r_idx < IDX_W'(DIM))),
        .i_waddr (r_idx[AW-1:0]),
        .i_wdata (i_s_tdata),
        .i_raddr (r_i),
        .o_rdata (x_q)
    );

    // score and margin
    assign score_sum = 64'(r_acc >>> 12) + 64'(r_bias);
    always_comb begin
        if (score_sum > 64'sd140737488355327)
            score_c = 48'sh7FFF_FFFF_FFFF;
        else if (score_sum < -64'sd140737488355328)
            score_c = 48'sh8000_0000_0000;
        else
            score_c = score_sum[47:0];
        if (y_zero)
            viol_c = 1'b1;
        else if (y_neg)
            viol_c = score_c > -48'sd16777216;
        else
            viol_c = score_c < 48'sd16777216;
    end

    assign learn   = r_viol && !y_zero && (r_isbias || (i_ext < r_count));
    assign dec_mag = abs32(r_w) - div_q[31:0] - {31'd0, div_rnz};
    assign upd_val = sat32(54'(r_dec) + 54'(r_d));

    // projection scale factor
    always_comb begin
        p_sum = {1'b0, r_phi[55:0], 8'd0} + 65'(r_prod[63:24]);
        if (r_phi >= 64'h0100_0000_0000_0000 || p_sum[64])
            p_val = '1;
        else
            p_val = p_sum[63:0];
    end

    // shared multiplier operands
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (r_state)
            S_MAC1: begin
                mul_a = 33'(w_rd);
                mul_b = 33'(r_x);
            end
            S_SCORE: begin
                mul_a = {1'b0, lr_val};
                mul_b = {1'b0, t_val};
            end
            S_NLAT: begin
                mul_a = 33'(w_rd);
                mul_b = 33'(w_rd);
            end
            S_PHI: begin
                mul_a = {1'b0, r_norm[63:32]};
                mul_b = {1'b0, lr_val};
            end
            S_PHI2: begin
                mul_a = {1'b0, r_norm[31:0]};
                mul_b = {1'b0, lr_val};
            end
            S_SLAT: begin
                mul_a = {1'b0, abs32(w_rd)};
                mul_b = {1'b0, r_scale};
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // divider and root requests
    always_comb begin
        div_req.start = 1'b0;
        div_req.num   = '0;
        div_req.den   = r_den;
        sq_start      = 1'b0;
        case (r_state)
            S_WLAT: begin
                div_req.start = 1'b1;
                div_req.num   = NUM_W'(abs32(w_rd));
                div_req.den   = DEN_W'(t_val);
            end
            S_BIAS: begin
                div_req.start = 1'b1;
                div_req.num   = NUM_W'(abs32(r_bias));
                div_req.den   = DEN_W'(t_val);
            end
            S_DIV1: begin
                div_req.start = div_done && learn;
                div_req.num   = r_isbias ? (NUM_W'(1) << 48) : {abs16(r_x), 36'd0};
            end
            S_PLO: begin
                sq_start = (p_val > 64'h1_0000_0000);
            end
            S_SQRT: begin
                div_req.start = sq_done;
                div_req.num   = NUM_W'(1) << 48;
                div_req.den   = DEN_W'(sq_root);
            end
            default: begin
                div_req.start = 1'b0;
            end
        endcase
    end

    osvm_div u_div (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_req    (div_req),
        .o_done   (div_done),
        .o_quo    (div_q),
        .o_rem_nz (div_rnz)
    );

    osvm_isqrt u_isqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (sq_start),
        .i_value (p_val),
        .o_done  (sq_done),
        .o_root  (sq_root)
    );

    always_ff @(posedge i_clk) begin
        r_prod  <= mul_a * mul_b;
        r_rdvld <= r_wvld[w_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_lambda  <= 32'd16777216;
            r_proj_en <= 1'b0;
            r_bias_en <= 1'b0;
            r_step    <= 32'd1;
            r_bias    <= '0;
            r_acc     <= '0;
            r_idx     <= '0;
            r_norm    <= '0;
            r_wvld    <= '0;
            ovalid    <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_addr)
                    CFG_REG_STRENGTH: r_lambda  <= i_cfg_wdata;
                    CFG_START_STEP:   r_step    <= {8'd0, i_cfg_wdata[23:0]};
                    CFG_PROJECT_EN:   r_proj_en <= i_cfg_wdata[0];
                    CFG_BIAS_EN:      r_bias_en <= i_cfg_wdata[0];
                    default: ;
                endcase
            end
            if (ovalid && i_m_tready && (r_state != S_OUT)) begin
                ovalid <= 1'b0;
            end
            if (w_we) begin
                r_wvld[r_i] <= 1'b1;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (s_acc) begin
                        r_x     <= $signed(i_s_tdata);
                        r_last  <= i_s_tlast;
                        r_lab   <= i_s_tuser[1:0];
                        r_act   <= i_s_tuser[2];
                        r_inr   <= r_idx < IDX_W'(DIM);
                        r_state <= S_MAC1;
                    end
                end
                S_MAC1: r_state <= S_MAC2;
                S_MAC2: begin
                    if (r_inr) begin
                        r_acc <= r_acc + ACC_W'(r_prod);
                        r_idx <= r_idx + 1'b1;
                    end
                    r_state <= r_last ? S_SCORE : S_IDLE;
                end
                S_SCORE: begin
                    r_score <= score_c;
                    r_viol  <= r_act && viol_c;
                    r_proj  <= 1'b0;
                    r_count <= r_idx;
                    r_acc   <= '0;
                    r_idx   <= '0;
                    r_state <= S_DEN;
                end
                S_DEN: begin
                    r_den <= r_prod[63:0];
                    r_i   <= '0;
                    r_state <= r_act ? S_WRD : S_OUT;
                end
                S_WRD: r_state <= S_WLAT;
                S_WLAT: begin
                    r_w      <= w_rd;
                    r_x      <= $signed(x_q);
                    r_isbias <= 1'b0;
                    r_state  <= S_DIV1;
                end
                S_BIAS: begin
                    r_w      <= r_bias;
                    r_isbias <= 1'b1;
                    r_state  <= S_DIV1;
                end
                S_DIV1: begin
                    if (div_done) begin
                        r_dec  <= r_w[31] ? -$signed({1'b0, dec_mag}) : $signed({1'b0, dec_mag});
                        r_d    <= '0;
                        r_dneg <= r_isbias ? y_neg : (r_x[15] != y_neg);
                        r_state <= learn ? S_DIV2 : S_WWR;
                    end
                end
                S_DIV2: begin
                    if (div_done) begin
                        r_d <= r_dneg ? -$signed({1'b0, div_q}) : $signed({1'b0, div_q});
                        r_state <= S_WWR;
                    end
                end
                S_WWR: begin
                    if (r_isbias) begin
                        r_bias  <= upd_val;
                        r_state <= S_PCHK;
                    end else if (i_at_end) begin
                        r_state <= r_bias_en ? S_BIAS : S_PCHK;
                    end else begin
                        r_i     <= r_i + 1'b1;
                        r_state <= S_WRD;
                    end
                end
                S_PCHK: begin
                    r_i    <= '0;
                    r_norm <= '0;
                    r_state <= r_proj_en ? S_NRD : S_STEP;
                end
                S_NRD: r_state <= S_NLAT;
                S_NLAT: r_state <= S_NACC;
                S_NACC: begin
                    r_norm <= r_norm + 64'(r_prod[63:16]);
                    if (i_at_end) begin
                        r_state <= S_PHI;
                    end else begin
                        r_i     <= r_i + 1'b1;
                        r_state <= S_NRD;
                    end
                end
                S_PHI: r_state <= S_PHI2;
                S_PHI2: begin
                    r_phi   <= r_prod[63:0];
                    r_state <= S_PLO;
                end
                S_PLO: r_state <= sq_start ? S_SQRT : S_STEP;
                S_SQRT: begin
                    if (sq_done) begin
                        r_state <= S_SDIV;
                    end
                end
                S_SDIV: begin
                    if (div_done) begin
                        r_scale <= (div_q > NUM_W'(32'hFFFF_FFFF)) ? 32'hFFFF_FFFF
                                                                   : div_q[31:0];
                        r_i     <= '0;
                        r_state <= S_SRD;
                    end
                end
                S_SRD: r_state <= S_SLAT;
                S_SLAT: begin
                    r_w     <= w_rd;
                    r_state <= S_SWR;
                end
                S_SWR: begin
                    if (i_at_end) begin
                        r_proj  <= 1'b1;
                        r_state <= S_STEP;
                    end else begin
                        r_i     <= r_i + 1'b1;
                        r_state <= S_SRD;
                    end
                end
                S_STEP: begin
                    if (r_step != 32'hFFFF_FFFF) begin
                        r_step <= r_step + 32'd1;
                    end
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (!ovalid || i_m_tready) begin
                        ovalid  <= 1'b1;
                        odata   <= r_score;
                        ouser   <= {r_proj, r_viol};
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_m_tvalid = ovalid;
    assign o_m_tdata  = odata;
    assign o_m_tuser  = ouser;

endmodule

`default_nettype wire
